>>> hdl/utf8_to_ucs2_strict_decoder_assert.svh
// Assertion macros for the checker file of the UTF-8 to UCS-2 decoder.
`ifndef UTF8_TO_UCS2_STRICT_DECODER_ASSERT_SVH
`define UTF8_TO_UCS2_STRICT_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U8U_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define U8U_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/u8u_pkg.sv
// Package with widths and result status codes of the UTF-8 to UCS-2 decoder.
package u8u_pkg;

  localparam int BYTE_W  = 8;
  localparam int UNIT_W  = 16;
  localparam int COUNT_W = 8;
  localparam int STAT_W  = 2;
  localparam int APB_AW  = 1;
  localparam int APB_DW  = 32;

  // Register addresses on the configuration port.
  localparam logic [APB_AW-1:0] ADDR_MAX_UNITS = 1'b0;

  localparam logic [COUNT_W-1:0] MAX_UNITS_RST = 8'd64;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_UNIT  = 2'd0;
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_ERROR = 2'd2;

  // Surrogate range, never a legal UCS-2 unit here.
  localparam logic [UNIT_W-1:0] SURR_LO = 16'hD800;
  localparam logic [UNIT_W-1:0] SURR_HI = 16'hDFFF;

endpackage

>>> hdl/utf8_to_ucs2_strict_decoder.sv
// Pipeline: an item is registered in the input register at acceptance and its result,
// if any, in the result register when that register is free or being drained.
// Throughput: one byte per cycle unless stalled; the decode state is the only loop.
// Reset (rst_n low, synchronous): decode state, unit count and skip flag clear,
// both pipeline registers empty, max_units returns to 64.
module utf8_to_ucs2_strict_decoder (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [u8u_pkg::BYTE_W-1:0]   in_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [u8u_pkg::UNIT_W-1:0]   out_code_unit,
  output logic [u8u_pkg::STAT_W-1:0]   out_status,
  output logic [u8u_pkg::COUNT_W-1:0]  out_unit_count,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [u8u_pkg::APB_AW-1:0]   paddr,
  input  logic [u8u_pkg::APB_DW-1:0]   pwdata,
  output logic [u8u_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import u8u_pkg::*;

  // Configuration register.
  logic [COUNT_W-1:0] max_units_r;

  // Input register.
  logic               s1_valid_r;
  logic [BYTE_W-1:0]  s1_byte_r;

  // Decode state.
  logic [1:0]         pending_r, pending_nxt;
  logic [1:0]         seq_len_r, seq_len_nxt;
  logic [UNIT_W-1:0]  partial_r, partial_nxt;
  logic [COUNT_W-1:0] units_r, units_nxt;
  logic               skip_r, skip_nxt;

  // Result register.
  logic               out_valid_r;
  logic [UNIT_W-1:0]  out_unit_r;
  logic [STAT_W-1:0]  out_status_r;
  logic [COUNT_W-1:0] out_count_r;

  // Result of the item in the input register.
  logic               res_valid;
  logic [UNIT_W-1:0]  res_unit;
  logic [STAT_W-1:0]  res_status;
  logic [COUNT_W-1:0] res_count;

  logic               advance;
  logic               do_emit;
  logic               do_fail;
  logic [UNIT_W-1:0]  emit_cp;
  logic [UNIT_W-1:0]  gathered;
  logic               wr_en;

  // The input register moves on when the result register is free or being drained.
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;

  // APB access: writes land on the access phase, reads are always ready.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == ADDR_MAX_UNITS);
  assign prdata = (paddr == ADDR_MAX_UNITS) ? {{(APB_DW-COUNT_W){1'b0}}, max_units_r}
                                            : '0;

  // Code point after appending the low six bits of a continuation byte.
  assign gathered = {partial_r[UNIT_W-7:0], s1_byte_r[5:0]};

  // Byte classification and decode state update.
  always_comb begin
    pending_nxt = pending_r;
    seq_len_nxt = seq_len_r;
    partial_nxt = partial_r;
    units_nxt   = units_r;
    skip_nxt    = skip_r;
    res_valid   = 1'b0;
    res_unit    = '0;
    res_status  = ST_UNIT;
    res_count   = units_r;
    do_emit     = 1'b0;
    do_fail     = 1'b0;
    emit_cp     = '0;

    if (skip_r) begin
      // Bytes after an error are dropped; the terminator restarts decoding.
      if (s1_byte_r == '0) begin
        skip_nxt    = 1'b0;
        pending_nxt = '0;
        seq_len_nxt = '0;
        partial_nxt = '0;
        units_nxt   = '0;
      end
    end else if (s1_byte_r == '0) begin
      // Terminator: done, or an error when a sequence is still open.
      res_valid   = 1'b1;
      res_status  = (pending_r != '0) ? ST_ERROR : ST_DONE;
      pending_nxt = '0;
      seq_len_nxt = '0;
      partial_nxt = '0;
      units_nxt   = '0;
    end else if (pending_r == '0) begin
      // Lead byte.
      if (!s1_byte_r[7]) begin
        do_emit = 1'b1;
        emit_cp = {{(UNIT_W-BYTE_W){1'b0}}, s1_byte_r};
      end else if (s1_byte_r[7:5] == 3'b110) begin
        partial_nxt = {{(UNIT_W-5){1'b0}}, s1_byte_r[4:0]};
        pending_nxt = 2'd1;
        seq_len_nxt = 2'd2;
      end else if (s1_byte_r[7:4] == 4'b1110) begin
        partial_nxt = {{(UNIT_W-4){1'b0}}, s1_byte_r[3:0]};
        pending_nxt = 2'd2;
        seq_len_nxt = 2'd3;
      end else begin
        do_fail = 1'b1;
      end
    end else if (s1_byte_r[7:6] != 2'b10) begin
      // Anything but a continuation byte inside a sequence.
      do_fail = 1'b1;
    end else if (pending_r != 2'd1) begin
      partial_nxt = gathered;
      pending_nxt = pending_r - 2'd1;
    end else begin
      // Last continuation byte: check for overlong forms and surrogates.
      pending_nxt = '0;
      seq_len_nxt = '0;
      partial_nxt = '0;
      if (seq_len_r == 2'd2) begin
        do_fail = (gathered < 16'h0080);
      end else begin
        do_fail = (gathered < 16'h0800) || ((gathered >= SURR_LO) && (gathered <= SURR_HI));
      end
      do_emit = !do_fail;
      emit_cp = gathered;
    end

    // A unit beyond the capacity turns into an error.
    if (do_emit && (units_r >= max_units_r)) begin
      do_emit = 1'b0;
      do_fail = 1'b1;
    end

    if (do_emit) begin
      units_nxt = units_r + 8'd1;
      res_valid = 1'b1;
      res_unit  = emit_cp;
      res_count = units_r + 8'd1;
    end

    if (do_fail) begin
      pending_nxt = '0;
      seq_len_nxt = '0;
      partial_nxt = '0;
      skip_nxt    = 1'b1;
      res_valid   = 1'b1;
      res_status  = ST_ERROR;
      res_unit    = '0;
      res_count   = units_r;
    end
  end

  // Registers: configuration, input stage, decode state and result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_units_r <= MAX_UNITS_RST;
      s1_valid_r  <= 1'b0;
      pending_r   <= '0;
      seq_len_r   <= '0;
      partial_r   <= '0;
      units_r     <= '0;
      skip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        max_units_r <= pwdata[COUNT_W-1:0];
      end

      if (in_valid && !in_stall) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_valid_r && advance) begin
        pending_r <= pending_nxt;
        seq_len_r <= seq_len_nxt;
        partial_r <= partial_nxt;
        units_r   <= units_nxt;
        skip_r    <= skip_nxt;
      end

      if (advance) begin
        out_valid_r <= s1_valid_r && res_valid;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_byte;
    end
    if (advance && s1_valid_r && res_valid) begin
      out_unit_r   <= res_unit;
      out_status_r <= res_status;
      out_count_r  <= res_count;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code_unit  = out_unit_r;
  assign out_status     = out_status_r;
  assign out_unit_count = out_count_r;

endmodule

>>> hdl/u8u_checker.sv
// Port-level checker for the UTF-8 to UCS-2 decoder, bound to the top level.
`include "utf8_to_ucs2_strict_decoder_assert.svh"

module u8u_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [u8u_pkg::BYTE_W-1:0]   in_byte,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [u8u_pkg::UNIT_W-1:0]   out_code_unit,
  input  logic [u8u_pkg::STAT_W-1:0]   out_status,
  input  logic [u8u_pkg::COUNT_W-1:0]  out_unit_count,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [u8u_pkg::APB_AW-1:0]   paddr,
  input  logic [u8u_pkg::APB_DW-1:0]   pwdata,
  input  logic [u8u_pkg::APB_DW-1:0]   prdata,
  input  logic                         pready
);
  import u8u_pkg::*;

  // Only the three defined status codes ever leave the block.
  `U8U_ASSERT_NOW(a_status_code, out_valid, (out_status == ST_UNIT) || (out_status == ST_DONE) || (out_status == ST_ERROR), "undefined result status")

  // A decoded unit is never a surrogate and always counts at least itself.
  `U8U_ASSERT_NOW(a_unit_legal, out_valid && (out_status == ST_UNIT), ((out_code_unit < SURR_LO) || (out_code_unit > SURR_HI)) && (out_unit_count != '0), "illegal decoded unit")

  // Done and error items carry no code unit.
  `U8U_ASSERT_NOW(a_no_unit_on_end, out_valid && (out_status != ST_UNIT), out_code_unit == '0, "code unit on a done or error item")

  // A stalled result holds.
  `U8U_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_code_unit) && $stable(out_status) && $stable(out_unit_count), "stalled result changed")

endmodule

bind utf8_to_ucs2_strict_decoder u8u_checker u_chk (.*);
